/* src/assert_macros.svh */
// assertion macros shared by the accelerometer calibration rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ACSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ACSV_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* src/acsv_pkg.sv */
// shared types, constants and register codes of the accelerometer calibration block
// no dependencies
package acsv_pkg;

    localparam int ACSV_OUT_WIDTH = 24;

    localparam int RAW_W     = 16;
    localparam int DIFF_W    = 17;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 4;

    // serial multiplier sizes
    localparam int MUL_AW = 72;
    localparam int MUL_BW = 40;
    localparam int MUL_NW = 6;

    // serial root sizes
    localparam int SQ_NW = 64;
    localparam int SQ_RW = 32;
    localparam int SQ_CW = 6;
    localparam int SQ_REM_W = SQ_RW + 4;

    // intermediate widths
    localparam int C_W  = 36;
    localparam int F_W  = 34;
    localparam int RG_W = 25;
    localparam int A_W  = 34;
    localparam int R_W  = 40;
    localparam int CMP_W = 33;
    localparam int LIM_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSETS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALES  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TCOEFF  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITS  = 4'd7;

    // register reset values
    localparam logic [47:0] RST_SCALES = 48'h400040004000;
    localparam logic [4:0]  RST_RANGE  = 5'd16;
    localparam logic [15:0] RST_TEMP   = 16'd5120;
    localparam logic [15:0] RST_TOL    = 16'd1024;
    localparam logic [47:0] RST_LIMITS = 48'h028000FD8000;

    // physical constants
    localparam logic [19:0]        G_Q16     = 20'd642689;
    localparam logic [CMP_W-1:0]   G_OUT     = 33'd10042;
    localparam logic [CMP_W-1:0]   MAG_FLOOR = 33'd1024;
    localparam logic signed [16:0] REF_TEMP  = 17'sd5120;
    localparam logic signed [F_W-1:0] F_ONE  = 34'sd16777216;
    localparam logic signed [MUL_AW-1:0] ROUND_HALF = 72'sd2147483648;

    // serial step counts for each product
    localparam logic [MUL_NW-1:0] NB_TEMP  = 6'd17;
    localparam logic [MUL_NW-1:0] NB_RANGE = 6'd6;
    localparam logic [MUL_NW-1:0] NB_SCALE = 6'd17;
    localparam logic [MUL_NW-1:0] NB_CROSS = 6'd17;
    localparam logic [MUL_NW-1:0] NB_RG    = 6'd26;
    localparam logic [MUL_NW-1:0] NB_F     = 6'd34;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEMP,
        ST_RNG,
        ST_PROD0,
        ST_PROD1,
        ST_PROD2,
        ST_SCL,
        ST_RND,
        ST_SQR,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MUL_NW-1:0] nbits;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* src/acsv_in_if.sv */
// request channel carrying one raw accelerometer triple
// depends on acsv_pkg
interface acsv_in_if import acsv_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

/* src/acsv_out_if.sv */
// result channel carrying calibrated axes, magnitude, check flag and count
// depends on acsv_pkg
interface acsv_out_if import acsv_pkg::*; #(
    parameter int OUT_WIDTH = ACSV_OUT_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] accel_x;
    logic signed [OUT_WIDTH-1:0] accel_y;
    logic signed [OUT_WIDTH-1:0] accel_z;
    logic [OUT_WIDTH-1:0]        magnitude;
    logic                        valid_res;
    logic [CNT_W-1:0]            frame_count;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output magnitude, output valid_res, output frame_count, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input magnitude, input valid_res, input frame_count, output ready);
endinterface

/* src/acsv_mul.sv */
// bit-serial signed multiplier, one multiplier bit per cycle, lsb first
// depends on acsv_pkg
module acsv_mul import acsv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_ctl                 i_ctl,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic [MUL_BW-1:0]        i_b,
    output t_unit_stat               o_stat,
    output logic signed [MUL_AW-1:0] o_p
);
    logic signed [MUL_AW-1:0] r_a;
    logic [MUL_BW-1:0]        r_b;
    logic signed [MUL_AW-1:0] r_p;
    logic signed [MUL_AW-1:0] n_p;
    logic [MUL_NW-1:0]        r_n;
    logic                     r_busy;
    logic                     r_done;

    // top bit of the multiplier carries negative weight
    always_comb begin
        n_p = r_p;
        if (r_b[0]) begin
            n_p = (r_n == MUL_NW'(1)) ? r_p - r_a : r_p + r_a;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_n    <= i_ctl.nbits;
            end else if (r_busy) begin
                r_n <= r_n - MUL_NW'(1);
                if (r_n == MUL_NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
            r_p <= n_p;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_p         = r_p;
endmodule

/* src/acsv_sqrt.sv */
// digit-by-digit integer square root, two radicand bits per cycle
// depends on acsv_pkg
module acsv_sqrt import acsv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_NW-1:0] i_n,
    output t_unit_stat       o_stat,
    output logic [SQ_RW-1:0] o_root
);
    logic [SQ_NW-1:0]    r_n;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_RW-1:0]    r_root;
    logic [SQ_CW-1:0]    r_i;
    logic                r_busy;
    logic                r_done;
    logic [SQ_REM_W-1:0] w_rem_sh;
    logic [SQ_REM_W-1:0] w_trial;
    logic                w_ge;

    // trial subtract of 4*root+1
    assign w_rem_sh = {r_rem[SQ_REM_W-3:0], r_n[SQ_NW-1:SQ_NW-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= SQ_CW'(SQ_RW);
            end else if (r_busy) begin
                r_i <= r_i - SQ_CW'(1);
                if (r_i == SQ_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // radicand, remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= r_n << 2;
            r_rem  <= w_ge ? w_rem_sh - w_trial : w_rem_sh;
            r_root <= {r_root[SQ_RW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;
endmodule

/* src/accel_calibrate_scale_validate_unit.sv */
// accelerometer calibration: offset, gain, cross-coupling, range, temperature, magnitude, checks
// depends on acsv_pkg, acsv_in_if, acsv_out_if, acsv_mul, acsv_sqrt, assert_macros.svh
// one request at a time, set by the serial multiplier and root; a new request is taken only in idle
// the next request is taken while a finished result waits in the output register
// reset: synchronous active low, registers to documented values, sample counter to zero
`include "assert_macros.svh"

module accel_calibrate_scale_validate_unit import acsv_pkg::*; #(
    parameter int OUT_WIDTH = ACSV_OUT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    acsv_in_if.sink              i_smp,
    acsv_out_if.source           o_res
);
    localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);
    localparam logic [CMP_W-1:0]      MAG_MAX = (CMP_W'(1) << OUT_WIDTH) - CMP_W'(1);

    // configuration registers
    logic [47:0] r_off;
    logic [47:0] r_scl;
    logic [31:0] r_kx;
    logic [4:0]  r_rng;
    logic [15:0] r_temp;
    logic [23:0] r_tc;
    logic [15:0] r_tol;
    logic [47:0] r_lim;

    // sequencer and datapath
    t_state                      r_state;
    t_state                      n_state;
    logic                        r_go;
    logic [1:0]                  r_axis;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [DIFF_W-1:0]    r_dx;
    logic signed [DIFF_W-1:0]    r_dy;
    logic signed [DIFF_W-1:0]    r_dz;
    logic signed [F_W-1:0]       r_f;
    logic [RG_W-1:0]             r_rg;
    logic signed [C_W-1:0]       r_c;
    logic signed [A_W-1:0]       r_a;
    logic signed [OUT_WIDTH-1:0] r_ax;
    logic signed [OUT_WIDTH-1:0] r_ay;
    logic signed [OUT_WIDTH-1:0] r_az;
    logic [SQ_NW-1:0]            r_sum;
    logic                        r_ok;
    logic [OUT_WIDTH-1:0]        r_mag;

    // output register
    logic                        r_o_valid;
    logic signed [OUT_WIDTH-1:0] r_o_x;
    logic signed [OUT_WIDTH-1:0] r_o_y;
    logic signed [OUT_WIDTH-1:0] r_o_z;
    logic [OUT_WIDTH-1:0]        r_o_mag;
    logic                        r_o_ok;
    logic [CNT_W-1:0]            r_o_cnt;

    logic                        in_ready;
    logic                        in_acc;
    logic                        out_load;
    t_mul_ctl                    mul_ctl;
    t_unit_stat                  mul_stat;
    logic signed [MUL_AW-1:0]    mul_a;
    logic [MUL_BW-1:0]           mul_b;
    logic signed [MUL_AW-1:0]    mul_p;
    logic                        sq_start;
    t_unit_stat                  sq_stat;
    logic [SQ_RW-1:0]            sq_root;

    logic signed [15:0]          w_kxy;
    logic signed [15:0]          w_kxz;
    logic signed [23:0]          w_tc;
    logic signed [16:0]          w_dtemp;
    logic signed [DIFF_W-1:0]    w_d_cur;
    logic [15:0]                 w_s_cur;
    logic signed [15:0]          w_k_cur;
    logic signed [DIFF_W-1:0]    w_d_oth;
    logic signed [OUT_WIDTH-1:0] w_axis_cur;
    logic signed [MUL_AW-1:0]    w_rsum;
    logic signed [R_W-1:0]       w_r;
    logic signed [R_W-1:0]       w_sat;
    logic signed [CMP_W-1:0]     w_axis33;
    logic signed [CMP_W-1:0]     w_lo33;
    logic signed [CMP_W-1:0]     w_hi33;
    logic                        w_in_lim;
    logic [CMP_W-1:0]            w_mag33;
    logic [CMP_W-1:0]            w_dev;
    logic [CMP_W-1:0]            w_tol3;
    logic                        w_grav_fail;

    // register field views
    assign w_kxy   = signed'(r_kx[15:0]);
    assign w_kxz   = signed'(r_kx[31:16]);
    assign w_tc    = signed'(r_tc);
    assign w_dtemp = 17'(signed'(r_temp)) - REF_TEMP;

    // per-axis operand selection
    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                w_d_cur    = r_dx;
                w_s_cur    = r_scl[15:0];
                w_k_cur    = w_kxy;
                w_d_oth    = r_dy;
                w_axis_cur = r_ax;
            end
            AXIS_Y: begin
                w_d_cur    = r_dy;
                w_s_cur    = r_scl[31:16];
                w_k_cur    = w_kxy;
                w_d_oth    = r_dx;
                w_axis_cur = r_ay;
            end
            default: begin
                w_d_cur    = r_dz;
                w_s_cur    = r_scl[47:32];
                w_k_cur    = w_kxz;
                w_d_oth    = r_dx;
                w_axis_cur = r_az;
            end
        endcase
    end

    // rounding and saturation of one axis
    assign w_rsum = mul_p + ROUND_HALF;
    assign w_r    = w_rsum[MUL_AW-1:32];
    assign w_sat  = (w_r > SAT_HI) ? SAT_HI : ((w_r < SAT_LO) ? SAT_LO : w_r);

    // axis limit check
    assign w_axis33 = CMP_W'(w_axis_cur);
    assign w_lo33   = CMP_W'(signed'(r_lim[LIM_W-1:0]));
    assign w_hi33   = CMP_W'(signed'(r_lim[2*LIM_W-1:LIM_W]));
    assign w_in_lim = (w_axis33 >= w_lo33) && (w_axis33 <= w_hi33);

    // gravity check
    assign w_mag33     = CMP_W'(r_mag);
    assign w_dev       = (w_mag33 > G_OUT) ? w_mag33 - G_OUT : G_OUT - w_mag33;
    assign w_tol3      = CMP_W'({r_tol, 1'b0}) + CMP_W'(r_tol);
    assign w_grav_fail = (w_dev > w_tol3) && (w_mag33 > MAG_FLOOR);

    assign in_acc      = i_smp.valid && in_ready;
    assign i_smp.ready = in_ready;

    // sequencer next state and unit operands
    always_comb begin
        n_state  = r_state;
        mul_ctl  = '0;
        mul_a    = '0;
        mul_b    = '0;
        sq_start = 1'b0;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_smp.valid) begin
                    n_state = ST_TEMP;
                end
            end
            ST_TEMP: begin
                mul_a         = MUL_AW'(w_tc);
                mul_b         = MUL_BW'(w_dtemp);
                mul_ctl.nbits = NB_TEMP;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = ST_RNG;
                end
            end
            ST_RNG: begin
                mul_a         = MUL_AW'(G_Q16);
                mul_b         = MUL_BW'(r_rng);
                mul_ctl.nbits = NB_RANGE;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = ST_PROD0;
                end
            end
            ST_PROD0: begin
                mul_a         = MUL_AW'(w_d_cur) <<< 1;
                mul_b         = MUL_BW'(w_s_cur);
                mul_ctl.nbits = NB_SCALE;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = ST_PROD1;
                end
            end
            ST_PROD1: begin
                mul_a         = MUL_AW'(w_k_cur);
                mul_b         = MUL_BW'(w_d_oth);
                mul_ctl.nbits = NB_CROSS;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = (r_axis == AXIS_X) ? ST_PROD2 : ST_SCL;
                end
            end
            ST_PROD2: begin
                mul_a         = MUL_AW'(w_kxz);
                mul_b         = MUL_BW'(r_dz);
                mul_ctl.nbits = NB_CROSS;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = ST_SCL;
                end
            end
            ST_SCL: begin
                mul_a         = MUL_AW'(r_c);
                mul_b         = MUL_BW'(r_rg);
                mul_ctl.nbits = NB_RG;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                mul_a         = MUL_AW'(r_a);
                mul_b         = MUL_BW'(r_f);
                mul_ctl.nbits = NB_F;
                mul_ctl.start = !r_go;
                if (mul_stat.done) begin
                    n_state = (r_axis == AXIS_LAST) ? ST_SQR : ST_PROD0;
                end
            end
            ST_SQR: begin
                mul_a         = MUL_AW'(w_axis_cur);
                mul_b         = MUL_BW'(w_axis_cur);
                mul_ctl.nbits = MUL_NW'(OUT_WIDTH);
                mul_ctl.start = !r_go;
                if (mul_stat.done && (r_axis == AXIS_LAST)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                sq_start = !r_go;
                if (sq_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, unit launch flag, axis index, sample counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_axis  <= AXIS_X;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (mul_ctl.start || sq_start) begin
                r_go <= 1'b1;
            end else if (mul_stat.done || sq_stat.done) begin
                r_go <= 1'b0;
            end
            if (in_acc) begin
                r_axis <= AXIS_X;
                r_cnt  <= r_cnt + CNT_W'(1);
            end else if (mul_stat.done && (r_state == ST_RND || r_state == ST_SQR)) begin
                r_axis <= (r_axis == AXIS_LAST) ? AXIS_X : r_axis + 2'd1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_scl  <= RST_SCALES;
            r_kx   <= '0;
            r_rng  <= RST_RANGE;
            r_temp <= RST_TEMP;
            r_tc   <= '0;
            r_tol  <= RST_TOL;
            r_lim  <= RST_LIMITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSETS: r_off  <= i_cfg_data;
                REG_SCALES:  r_scl  <= i_cfg_data;
                REG_CROSS:   r_kx   <= i_cfg_data[31:0];
                REG_RANGE:   r_rng  <= i_cfg_data[4:0];
                REG_TEMP:    r_temp <= i_cfg_data[15:0];
                REG_TCOEFF:  r_tc   <= i_cfg_data[23:0];
                REG_TOL:     r_tol  <= i_cfg_data[15:0];
                REG_LIMITS:  r_lim  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dx  <= DIFF_W'(i_smp.raw_x) - DIFF_W'(signed'(r_off[15:0]));
            r_dy  <= DIFF_W'(i_smp.raw_y) - DIFF_W'(signed'(r_off[31:16]));
            r_dz  <= DIFF_W'(i_smp.raw_z) - DIFF_W'(signed'(r_off[47:32]));
            r_sum <= '0;
            r_ok  <= 1'b1;
        end
        if (mul_stat.done) begin
            unique case (r_state)
                ST_TEMP:  r_f  <= F_ONE + signed'(mul_p[F_W+7:8]);
                ST_RNG:   r_rg <= mul_p[RG_W-1:0];
                ST_PROD0: r_c  <= mul_p[C_W-1:0];
                ST_PROD1: r_c  <= r_c + mul_p[C_W-1:0];
                ST_PROD2: r_c  <= r_c + mul_p[C_W-1:0];
                ST_SCL:   r_a  <= mul_p[A_W+27:28];
                ST_RND: begin
                    unique case (r_axis)
                        AXIS_X:  r_ax <= OUT_WIDTH'(w_sat);
                        AXIS_Y:  r_ay <= OUT_WIDTH'(w_sat);
                        default: r_az <= OUT_WIDTH'(w_sat);
                    endcase
                end
                ST_SQR: begin
                    r_sum <= r_sum + mul_p[SQ_NW-1:0];
                    r_ok  <= r_ok && w_in_lim;
                end
                default: begin
                end
            endcase
        end
        if (sq_stat.done) begin
            r_mag <= (CMP_W'(sq_root) > MAG_MAX) ? OUT_WIDTH'(MAG_MAX) : OUT_WIDTH'(sq_root);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_x   <= r_ax;
            r_o_y   <= r_ay;
            r_o_z   <= r_az;
            r_o_mag <= r_mag;
            r_o_ok  <= r_ok && !w_grav_fail;
            r_o_cnt <= r_cnt;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.accel_x     = r_o_x;
    assign o_res.accel_y     = r_o_y;
    assign o_res.accel_z     = r_o_z;
    assign o_res.magnitude   = r_o_mag;
    assign o_res.valid_res   = r_o_ok;
    assign o_res.frame_count = r_o_cnt;

    acsv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_p     (mul_p)
    );

    acsv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (r_sum),
        .o_stat  (sq_stat),
        .o_root  (sq_root)
    );

    // assertions
    `ACSV_ASSERT(a_accept_starts, in_acc |=> (r_state == ST_TEMP), "request did not start work")
    `ACSV_NEVER(a_mul_overlap, mul_ctl.start && mul_stat.busy, "multiplier restarted while busy")
    `ACSV_NEVER(a_done_mul_busy, (r_state == ST_DONE) && (mul_stat.busy || sq_stat.busy), "unit busy at result")
endmodule

/* bench/tb_accel_calibrate_scale_validate_unit.sv */
// self-checking bench for the accelerometer calibration unit: directed corners, then random traffic
// depends on acsv_pkg, acsv_in_if, acsv_out_if and accel_calibrate_scale_validate_unit
module tb_accel_calibrate_scale_validate_unit;
    import acsv_pkg::*;

    localparam int OW       = ACSV_OUT_WIDTH;
    localparam int LATENCY  = 3 * OW + 392;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [OW-1:0] accel_x;
        logic signed [OW-1:0] accel_y;
        logic signed [OW-1:0] accel_z;
        logic [OW-1:0]        magnitude;
        logic                 valid_res;
        logic [CNT_W-1:0]     frame_count;
    } t_calib;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    acsv_in_if  smp ();
    acsv_out_if res ();

    accel_calibrate_scale_validate_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp),
        .o_res      (res)
    );

    // bench copy of the register file and sample counter
    logic [47:0]      cal_regs [16];
    logic [CNT_W-1:0] shadow_count;
    t_calib           pending_calib [$];
    int               fail_count = 0;
    int               idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
    int               quiet_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sx(input logic [47:0] v, input int pos, input int w);
        longint r;
        r = longint'(v >> pos);
        r = r & ((64'sd1 <<< w) - 1);
        if (r[w-1]) r = r - (64'sd1 <<< w);
        return r;
    endfunction

    function automatic longint unsigned bit_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // one axis: range and g scaling, temperature factor with round half up, saturation
    function automatic longint scale_axis(input longint c, input longint rng, input longint f);
        longint a;
        longint r;
        longint hi;
        a  = (c * rng * 64'sd642689) >>> 28;
        r  = (a * f + (64'sd1 <<< 31)) >>> 32;
        hi = (64'sd1 <<< (OW - 1)) - 1;
        if (r > hi) r = hi;
        if (r < -hi - 1) r = -hi - 1;
        return r;
    endfunction

    function automatic t_calib calibrate(input logic [15:0] rx, input logic [15:0] ry,
                                         input logic [15:0] rz);
        t_calib o;
        longint dx, dy, dz, kxy, kxz, rng, f, lo, hi, ax, ay, az, dev;
        longint unsigned mag;
        logic ok;
        dx  = sx(rx, 0, 16) - sx(cal_regs[REG_OFFSETS], 0, 16);
        dy  = sx(ry, 0, 16) - sx(cal_regs[REG_OFFSETS], 16, 16);
        dz  = sx(rz, 0, 16) - sx(cal_regs[REG_OFFSETS], 32, 16);
        kxy = sx(cal_regs[REG_CROSS], 0, 16);
        kxz = sx(cal_regs[REG_CROSS], 16, 16);
        rng = longint'(cal_regs[REG_RANGE][4:0]);
        f   = (64'sd1 <<< 24) + ((sx(cal_regs[REG_TCOEFF], 0, 24) *
              (sx(cal_regs[REG_TEMP], 0, 16) - 5120)) >>> 8);
        lo  = sx(cal_regs[REG_LIMITS], 0, 24);
        hi  = sx(cal_regs[REG_LIMITS], 24, 24);
        ax  = scale_axis(2 * dx * longint'(cal_regs[REG_SCALES][15:0]) + kxy * dy + kxz * dz,
                         rng, f);
        ay  = scale_axis(2 * dy * longint'(cal_regs[REG_SCALES][31:16]) + kxy * dx, rng, f);
        az  = scale_axis(2 * dz * longint'(cal_regs[REG_SCALES][47:32]) + kxz * dx, rng, f);
        mag = bit_root(longint'(ax * ax + ay * ay + az * az));
        if (mag > (64'd1 << OW) - 1) mag = (64'd1 << OW) - 1;
        dev = 10042 - longint'(mag);
        if (dev < 0) dev = -dev;
        ok = 1'b1;
        if (dev > 3 * longint'(cal_regs[REG_TOL][15:0]) && mag > 1024) ok = 1'b0;
        if (ax < lo || ax > hi || ay < lo || ay > hi || az < lo || az > hi) ok = 1'b0;
        shadow_count  = shadow_count + 1;
        o.accel_x     = ax[OW-1:0];
        o.accel_y     = ay[OW-1:0];
        o.accel_z     = az[OW-1:0];
        o.magnitude   = mag[OW-1:0];
        o.valid_res   = ok;
        o.frame_count = shadow_count;
        return o;
    endfunction

    // send one request, with a random gap before it as the idle mode asks
    task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] rz);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 27 : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            smp.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        smp.valid <= 1'b1;
        smp.raw_x <= rx;
        smp.raw_y <= ry;
        smp.raw_z <= rz;
        do @(posedge i_clk); while (!smp.ready);
        pending_calib.push_back(calibrate(rx, ry, rz));
    endtask

    // wait for every result, then let the pipeline settle before touching registers
    task automatic drain_results();
        @(posedge i_clk);
        smp.valid <= 1'b0;
        while (pending_calib.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        int wid [8] = '{48, 48, 32, 5, 16, 24, 16, 48};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < 8) cal_regs[idx] = val & 48'((49'd1 << wid[idx[2:0]]) - 49'd1);
    endtask

    // field extremes at reset settings
    task automatic test_reset_corners();
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h0000, 16'h0800);
        send_sample(16'hFFFF, 16'h0001, 16'hF800);
        drain_results();
    endtask

    // range zero, largest written range, unit range, with offsets and cross terms
    task automatic test_range_extremes();
        write_reg(REG_OFFSETS, 48'h8000_7FFF_1234);
        write_reg(REG_CROSS, 48'h8000_7FFF);
        write_reg(REG_SCALES, 48'hFFFF_0000_FFFF);
        write_reg(REG_RANGE, 48'd0);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        drain_results();
        write_reg(REG_RANGE, 48'd31);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        drain_results();
        write_reg(REG_RANGE, 48'd1);
        send_sample(16'h8000, 16'h7FFF, 16'h0000);
        drain_results();
    endtask

    // negative temperature factor flips the signs
    task automatic test_negative_temp_factor();
        write_reg(REG_OFFSETS, 48'd0);
        write_reg(REG_CROSS, 48'd0);
        write_reg(REG_SCALES, RST_SCALES);
        write_reg(REG_RANGE, 48'd16);
        write_reg(REG_TEMP, 48'h7FFF);
        write_reg(REG_TCOEFF, 48'hFF_FFFF & 48'h80_0000);
        send_sample(16'h1000, 16'hF000, 16'h0800);
        drain_results();
        write_reg(REG_TEMP, 48'h8000);
        write_reg(REG_TCOEFF, 48'h7F_FFFF);
        send_sample(16'h1000, 16'hF000, 16'h0800);
        drain_results();
        write_reg(REG_TEMP, RST_TEMP);
        write_reg(REG_TCOEFF, 48'd0);
    endtask

    // lower limit above upper limit fails every sample; the full-scale limits are then tried too
    task automatic test_inverted_limits();
        write_reg(REG_LIMITS, {24'hFF0000, 24'h010000});
        send_sample(16'h0000, 16'h0000, 16'h0800);
        drain_results();
        write_reg(REG_LIMITS, {24'h7FFFFF, 24'h800000});
        send_sample(16'h0000, 16'h0000, 16'h0800);
        drain_results();
    endtask

    // deviation between one and three tolerances passes, beyond three fails
    task automatic test_tolerance_band();
        write_reg(REG_TOL, 48'd100);
        send_sample(16'h0000, 16'h0000, 16'h0830);
        send_sample(16'h0000, 16'h0000, 16'h0860);
        send_sample(16'h0010, 16'h0000, 16'h0010);
        drain_results();
        write_reg(REG_TOL, 48'hFFFF);
        send_sample(16'h4000, 16'h4000, 16'h4000);
        drain_results();
        write_reg(REG_TOL, 48'd0);
        send_sample(16'h0000, 16'h0000, 16'h0800);
        drain_results();
    endtask

    // writes to indexes past the last register change nothing
    task automatic test_unused_index();
        write_reg(4'd9, 48'hFFFF_FFFF_FFFF);
        write_reg(4'd15, 48'h0);
        write_reg(REG_TOL, RST_TOL);
        send_sample(16'h0100, 16'h0200, 16'h0800);
        drain_results();
    endtask

    // random settings, mostly near-realistic
    task automatic randomize_regs(input bit wild);
        logic [47:0] v;
        if (wild) begin
            for (int r = 0; r < 8; r++) begin
                v = 48'({$urandom, $urandom});
                write_reg(r[CFG_IDX_W-1:0], v);
            end
        end else begin
            v = {4'h0, 12'($urandom_range(0, 511)), 4'h0, 12'($urandom_range(0, 511)),
                 4'h0, 12'($urandom_range(0, 511))};
            write_reg(REG_OFFSETS, v - 48'h000001000100 * $urandom_range(0, 1));
            write_reg(REG_SCALES, {16'($urandom_range(15000, 17800)),
                                   16'($urandom_range(15000, 17800)),
                                   16'($urandom_range(15000, 17800))});
            write_reg(REG_CROSS, {16'($signed($urandom_range(0, 2000)) - 1000),
                                  16'($signed($urandom_range(0, 2000)) - 1000)});
            write_reg(REG_RANGE, 48'(2 ** $urandom_range(1, 4)));
            write_reg(REG_TEMP, 48'(16'($urandom_range(0, 16000) - 3000)));
            write_reg(REG_TCOEFF, 48'(24'($signed($urandom_range(0, 4000)) - 2000)));
            write_reg(REG_TOL, 48'($urandom_range(50, 3000)));
            write_reg(REG_LIMITS, {24'($urandom_range(20000, 400000)),
                                   24'(-$signed($urandom_range(20000, 400000)))});
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] rx, ry, rz;
        int g;
        for (int ph = 0; ph < 12; ph++) begin
            idle_mode = ph % 4;
            randomize_regs(ph % 3 == 2);
            for (int n = 0; n < 110; n++) begin
                if (ph == 5 && n == 50) begin
                    // hold off until the unit has nothing outstanding
                    @(posedge i_clk);
                    smp.valid <= 1'b0;
                    while (pending_calib.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 99) < 70) begin
                    // gravity-like sample in the current range
                    g  = 65536 / (2 * int'(cal_regs[REG_RANGE][4:0]) + 1);
                    rx = 16'($signed($urandom_range(0, 2 * g)) - g);
                    ry = 16'($signed($urandom_range(0, 2 * g)) - g);
                    rz = 16'($signed($urandom_range(0, g / 4)) + g - g / 8);
                    if ($urandom_range(0, 1)) rz = -rz;
                end else begin
                    rx = 16'($urandom);
                    ry = 16'($urandom);
                    rz = 16'($urandom);
                end
                send_sample(rx, ry, rz);
            end
            drain_results();
        end
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_calib got;
        t_calib want;
        int stall_pct;
        if (res.valid && res.ready) begin
            got = '{res.accel_x, res.accel_y, res.accel_z, res.magnitude,
                    res.valid_res, res.frame_count};
            if (pending_calib.size() == 0) begin
                $error("unexpected result, count %0d", got.frame_count);
                fail_count++;
            end else begin
                want = pending_calib.pop_front();
                if (got.accel_x !== want.accel_x) begin
                    $error("accel_x exp %0d got %0d", want.accel_x, got.accel_x);
                    fail_count++;
                end
                if (got.accel_y !== want.accel_y) begin
                    $error("accel_y exp %0d got %0d", want.accel_y, got.accel_y);
                    fail_count++;
                end
                if (got.accel_z !== want.accel_z) begin
                    $error("accel_z exp %0d got %0d", want.accel_z, got.accel_z);
                    fail_count++;
                end
                if (got.magnitude !== want.magnitude) begin
                    $error("magnitude exp %0d got %0d", want.magnitude, got.magnitude);
                    fail_count++;
                end
                if (got.valid_res !== want.valid_res) begin
                    $error("valid_res exp %0d got %0d", want.valid_res, got.valid_res);
                    fail_count++;
                end
                if (got.frame_count !== want.frame_count) begin
                    $error("frame_count exp %0d got %0d", want.frame_count,
                           got.frame_count);
                    fail_count++;
                end
            end
        end
        stall_pct = (idle_mode == 2) ? 68 : (idle_mode == 3) ? 27 : 0;
        res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles without any accepted request, result or register write
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sequence of tests
    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        smp.valid  <= 1'b0;
        smp.raw_x  <= '0;
        smp.raw_y  <= '0;
        smp.raw_z  <= '0;
        idle_mode    = 0;
        shadow_count = '0;
        cal_regs = '{0: 48'd0, 1: RST_SCALES, 2: 48'd0, 3: 48'(RST_RANGE), 4: 48'(RST_TEMP),
                     5: 48'd0, 6: 48'(RST_TOL), 7: RST_LIMITS, default: 48'd0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_corners();
        test_range_extremes();
        test_negative_temp_factor();
        test_inverted_limits();
        test_tolerance_band();
        test_unused_index();
        test_random_traffic();
        drain_results();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/acsv_pkg.sv
src/acsv_in_if.sv
src/acsv_out_if.sv
src/acsv_mul.sv
src/acsv_sqrt.sv
src/accel_calibrate_scale_validate_unit.sv
bench/tb_accel_calibrate_scale_validate_unit.sv
